// ===== hw/rtl/campaign_auction_match_top_macros.svh =====
// Assertion macros shared by the campaign auction match RTL.
// Each macro expands to one labeled concurrent assertion with reset disable.
`ifndef CAMPAIGN_AUCTION_MATCH_TOP_MACROS_SVH
`define CAMPAIGN_AUCTION_MATCH_TOP_MACROS_SVH

// Same-cycle implication.
`define CAM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CAM_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/cam_pkg.sv =====
// Shared types and constants for the campaign auction match block.
// No dependencies.
`default_nettype none

package cam_pkg;

    localparam int MAX_ENTRIES_DEF = 64;

    // Result status codes
    localparam logic [1:0] ST_ADDED = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_FOUND = 2'd2;
    localparam logic [1:0] ST_NONE  = 2'd3;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_MATCH = 1'b1;

    // One stored campaign, the word kept in the table memory
    typedef struct packed {
        logic [31:0] id;
        logic [31:0] price;
        logic [15:0] country;
        logic [15:0] width;
        logic [15:0] height;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // One input item
    typedef struct packed {
        logic        cmd;
        logic [31:0] camp_id;
        logic [31:0] camp_price;
        logic [15:0] country_code;
        logic [15:0] camp_width;
        logic [15:0] camp_height;
        logic [31:0] floor_price;
        logic        has_banner;
        logic [15:0] banner_width;
        logic [15:0] banner_height;
    } req_t;

    // One result item
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] win_id;
        logic [31:0] win_price;
        logic [15:0] win_width;
        logic [15:0] win_height;
    } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cam_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
`default_nettype none

module cam_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/cam_ctrl.sv =====
// Table controller: appends campaigns and runs the match scan over the RAM.
// Depends on cam_pkg, cam_ram and the assertion macro header.
`default_nettype none
`include "campaign_auction_match_top_macros.svh"

module cam_ctrl #(
    parameter int MAX_ENTRIES = cam_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire cam_pkg::req_t in_req,
    output logic               res_valid,
    input  wire logic          res_take,
    output cam_pkg::res_t      res
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_RESP = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [AW-1:0]         addr_reg, addr_next;
    logic                  pend_reg, pend_next;
    logic                  last_reg, last_next;
    logic                  issued_reg, issued_next;
    logic                  found_reg, found_next;
    cam_pkg::entry_t       best_reg, best_next;
    cam_pkg::req_t         req_reg, req_next;
    cam_pkg::res_t         res_reg, res_next;

    logic                  in_accept;
    logic                  full;
    logic                  ram_we;
    logic [AW-1:0]         ram_addr;
    cam_pkg::entry_t       wr_entry;
    logic [cam_pkg::ENTRY_W-1:0] rd_data;
    cam_pkg::entry_t       rd_entry;
    logic                  hit;
    logic                  take;
    logic                  fin_found;
    cam_pkg::entry_t       fin_best;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_accept = in_valid && in_ready;
    assign full      = (count_reg == CW'(MAX_ENTRIES));
    assign res_valid = (state_reg == S_RESP);
    assign res       = res_reg;

    assign wr_entry.id      = in_req.camp_id;
    assign wr_entry.price   = in_req.camp_price;
    assign wr_entry.country = in_req.country_code;
    assign wr_entry.width   = in_req.camp_width;
    assign wr_entry.height  = in_req.camp_height;

    // writes only happen from idle and reads only during the scan, so the
    // two never touch the same entry in overlapping cycles
    assign ram_we   = in_accept && (in_req.cmd == cam_pkg::CMD_ADD) && !full;
    assign ram_addr = ram_we ? count_reg[AW-1:0] : addr_reg;

    cam_ram #(
        .WIDTH (cam_pkg::ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (wr_entry),
        .rdata (rd_data)
    );

    assign rd_entry = cam_pkg::entry_t'(rd_data);

    assign hit = (rd_entry.country == req_reg.country_code)
              && (rd_entry.price >= req_reg.floor_price)
              && (!req_reg.has_banner
                  || ((rd_entry.width == req_reg.banner_width)
                      && (rd_entry.height == req_reg.banner_height)));
    // strict greater keeps the earliest entry on a tie
    assign take = pend_reg && hit && (!found_reg || (rd_entry.price > best_reg.price));

    assign fin_found = found_reg || take;
    assign fin_best  = take ? rd_entry : best_reg;

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        addr_next   = addr_reg;
        pend_next   = 1'b0;
        last_next   = last_reg;
        issued_next = issued_reg;
        found_next  = fin_found;
        best_next   = fin_best;
        req_next    = req_reg;
        res_next    = res_reg;

        case (state_reg)
            S_IDLE: begin
                if (in_accept) begin
                    req_next    = in_req;
                    res_next    = '0;
                    found_next  = 1'b0;
                    addr_next   = '0;
                    issued_next = 1'b0;
                    if (in_req.cmd == cam_pkg::CMD_ADD) begin
                        state_next = S_RESP;
                        if (full) begin
                            res_next.status = cam_pkg::ST_FULL;
                        end else begin
                            res_next.status = cam_pkg::ST_ADDED;
                            count_next      = count_reg + CW'(1);
                        end
                    end else if (count_reg == '0) begin
                        res_next.status = cam_pkg::ST_NONE;
                        state_next      = S_RESP;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (!issued_reg) begin
                    pend_next = 1'b1;
                    last_next = (CW'(addr_reg) == count_reg - CW'(1));
                    if (CW'(addr_reg) == count_reg - CW'(1)) begin
                        issued_next = 1'b1;
                    end else begin
                        addr_next = addr_reg + AW'(1);
                    end
                end
                if (pend_reg && last_reg) begin
                    state_next = S_RESP;
                    if (fin_found) begin
                        res_next.status     = cam_pkg::ST_FOUND;
                        res_next.win_id     = fin_best.id;
                        res_next.win_price  = fin_best.price;
                        res_next.win_width  = fin_best.width;
                        res_next.win_height = fin_best.height;
                    end else begin
                        res_next        = '0;
                        res_next.status = cam_pkg::ST_NONE;
                    end
                end
            end
            S_RESP: begin
                if (res_take) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            pend_reg   <= 1'b0;
            issued_reg <= 1'b0;
            found_reg  <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            pend_reg   <= pend_next;
            issued_reg <= issued_next;
            found_reg  <= found_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg <= addr_next;
        last_reg <= last_next;
        best_reg <= best_next;
        req_reg  <= req_next;
        res_reg  <= res_next;
    end

    `CAM_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CW'(MAX_ENTRIES), "entry count above table size")
    `CAM_ASSERT_IMP(a_no_write_in_scan, aclk, aresetn, state_reg == S_SCAN, !ram_we, "table write during scan")
    `CAM_ASSERT_NXT(a_add_counts, aclk, aresetn, ram_we, count_reg == $past(count_reg) + CW'(1), "add did not bump count")
    `CAM_ASSERT_NXT(a_res_hold, aclk, aresetn, res_valid && !res_take, res_valid && $stable(res_reg), "pending result changed")

endmodule

`default_nettype wire

// ===== hw/rtl/campaign_auction_match_top.sv =====
// Campaign table with first-price match: top level with the output register.
// Depends on cam_pkg, cam_ctrl (which holds the cam_ram table).
//
// Usage: s_ channel carries one item, add (cmd 0) or match (cmd 1); m_ channel
// returns exactly one result item per input item, in order. Both channels are
// valid/ready; an item moves when valid and ready are high at a rising edge.
// An add writes the table memory in the accept cycle; its result goes through
// the controller's response state and then the m_ output register. A match
// reads one stored entry per cycle from the single-port table RAM, which has a
// registered read; with an empty table the scan is skipped. s_ready is high only
// while the controller is idle, so the block takes no new item until the
// controller has handed its last result on to the m_ output register.
// A finished result sits in the m_ output register; the controller may take the
// next item meanwhile and parks its own result until the register frees up.
// When the receiver stalls, m_ fields hold steady and the block stops taking
// items once both the output register and the controller hold a result.
// Reset (aresetn low, synchronous) empties the table and drops any result in
// flight; no clearing pass is needed since only written entries are ever read.
`default_nettype none

module campaign_auction_match_top #(
    parameter int MAX_ENTRIES = cam_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_cmd,
    input  wire logic [31:0] s_camp_id,
    input  wire logic [31:0] s_camp_price,
    input  wire logic [15:0] s_country_code,
    input  wire logic [15:0] s_camp_width,
    input  wire logic [15:0] s_camp_height,
    input  wire logic [31:0] s_floor_price,
    input  wire logic        s_has_banner,
    input  wire logic [15:0] s_banner_width,
    input  wire logic [15:0] s_banner_height,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic [31:0]      m_win_id,
    output logic [31:0]      m_win_price,
    output logic [15:0]      m_win_width,
    output logic [15:0]      m_win_height
);

    cam_pkg::req_t in_req;
    cam_pkg::res_t ctrl_res;
    cam_pkg::res_t m_res_reg, m_res_next;
    logic          m_valid_reg, m_valid_next;
    logic          ctrl_res_valid;
    logic          out_free;
    logic          res_take;

    assign in_req.cmd           = s_cmd;
    assign in_req.camp_id       = s_camp_id;
    assign in_req.camp_price    = s_camp_price;
    assign in_req.country_code  = s_country_code;
    assign in_req.camp_width    = s_camp_width;
    assign in_req.camp_height   = s_camp_height;
    assign in_req.floor_price   = s_floor_price;
    assign in_req.has_banner    = s_has_banner;
    assign in_req.banner_width  = s_banner_width;
    assign in_req.banner_height = s_banner_height;

    cam_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_req    (in_req),
        .res_valid (ctrl_res_valid),
        .res_take  (res_take),
        .res       (ctrl_res)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign res_take = ctrl_res_valid && out_free;

    always_comb begin
        m_res_next   = m_res_reg;
        m_valid_next = m_valid_reg;
        if (res_take) begin
            m_res_next   = ctrl_res;
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_res_reg.status;
    assign m_win_id     = m_res_reg.win_id;
    assign m_win_price  = m_res_reg.win_price;
    assign m_win_width  = m_res_reg.win_width;
    assign m_win_height = m_res_reg.win_height;

endmodule

`default_nettype wire

// ===== tb/campaign_auction_match_top_test.sv =====
// Self-checking testbench for campaign_auction_match_top: campaign adds and best-match
// lookups, predicted in-line against a shadow campaign table and checked in order.
// Depends on cam_pkg and the campaign_auction_match_top RTL.
`default_nettype none

module campaign_auction_match_top_test;

    localparam int MAX_ENTRIES     = cam_pkg::MAX_ENTRIES_DEF;
    localparam int ITEMS_PER_PHASE = 475;
    localparam int CYCLE_LIMIT     = 1000000;

    localparam logic [15:0] CC_US = 16'h5553;
    localparam logic [15:0] CC_DE = 16'h4445;
    localparam logic [15:0] CC_FR = 16'h4652;
    localparam logic [15:0] CC_JP = 16'h4A50;

    typedef enum int {PACE_FREE, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH} pace_t;

    logic        aclk            = 1'b0;
    logic        aresetn         = 1'b0;
    logic        s_valid         = 1'b0;
    logic        s_ready;
    logic        s_cmd           = cam_pkg::CMD_ADD;
    logic [31:0] s_camp_id       = '0;
    logic [31:0] s_camp_price    = '0;
    logic [15:0] s_country_code  = '0;
    logic [15:0] s_camp_width    = '0;
    logic [15:0] s_camp_height   = '0;
    logic [31:0] s_floor_price   = '0;
    logic        s_has_banner    = 1'b0;
    logic [15:0] s_banner_width  = '0;
    logic [15:0] s_banner_height = '0;
    logic        m_valid;
    logic        m_ready         = 1'b0;
    logic [1:0]  m_status;
    logic [31:0] m_win_id;
    logic [31:0] m_win_price;
    logic [15:0] m_win_width;
    logic [15:0] m_win_height;

    // shadow of the campaign table
    int          tbl_count = 0;
    logic [31:0] tbl_id     [MAX_ENTRIES];
    logic [31:0] tbl_price  [MAX_ENTRIES];
    logic [15:0] tbl_country[MAX_ENTRIES];
    logic [15:0] tbl_width  [MAX_ENTRIES];
    logic [15:0] tbl_height [MAX_ENTRIES];

    cam_pkg::req_t request_queue[$];
    cam_pkg::res_t auction_outcomes[$];
    cam_pkg::req_t presented;

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          fail_count     = 0;
    int          items_sent     = 0;
    int          status_seen[4] = '{0, 0, 0, 0};
    int unsigned cycle_count    = 0;

    campaign_auction_match_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_camp_id      (s_camp_id),
        .s_camp_price   (s_camp_price),
        .s_country_code (s_country_code),
        .s_camp_width   (s_camp_width),
        .s_camp_height  (s_camp_height),
        .s_floor_price  (s_floor_price),
        .s_has_banner   (s_has_banner),
        .s_banner_width (s_banner_width),
        .s_banner_height(s_banner_height),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_win_id       (m_win_id),
        .m_win_price    (m_win_price),
        .m_win_width    (m_win_width),
        .m_win_height   (m_win_height)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Appends one item to the pending queue.
    task automatic queue_item(input cam_pkg::req_t rq);
        request_queue.insert(request_queue.size(), rq);
    endtask

    // Applies one accepted item to the shadow table and queues the outcome it must produce.
    task automatic predict_auction(input cam_pkg::req_t rq);
        cam_pkg::res_t r;
        logic found;
        int   best;
        r     = '0;
        found = 1'b0;
        best  = 0;
        if (rq.cmd == cam_pkg::CMD_ADD) begin
            if (tbl_count >= MAX_ENTRIES) begin
                r.status = cam_pkg::ST_FULL;
            end else begin
                tbl_id[tbl_count]      = rq.camp_id;
                tbl_price[tbl_count]   = rq.camp_price;
                tbl_country[tbl_count] = rq.country_code;
                tbl_width[tbl_count]   = rq.camp_width;
                tbl_height[tbl_count]  = rq.camp_height;
                tbl_count++;
                r.status = cam_pkg::ST_ADDED;
            end
        end else begin
            for (int i = 0; i < tbl_count; i++) begin
                if (tbl_country[i] == rq.country_code && tbl_price[i] >= rq.floor_price &&
                    (!rq.has_banner || (tbl_width[i] == rq.banner_width &&
                                        tbl_height[i] == rq.banner_height))) begin
                    // strict compare keeps the earliest entry on a price tie
                    if (!found || tbl_price[i] > tbl_price[best]) begin
                        best  = i;
                        found = 1'b1;
                    end
                end
            end
            if (found) begin
                r.status     = cam_pkg::ST_FOUND;
                r.win_id     = tbl_id[best];
                r.win_price  = tbl_price[best];
                r.win_width  = tbl_width[best];
                r.win_height = tbl_height[best];
            end else begin
                r.status = cam_pkg::ST_NONE;
            end
        end
        auction_outcomes.insert(auction_outcomes.size(), r);
    endtask

    function automatic cam_pkg::req_t make_add(input logic [31:0] id,
                                               input logic [31:0] price,
                                               input logic [15:0] cc, input logic [15:0] w,
                                               input logic [15:0] h);
        cam_pkg::req_t rq;
        rq               = '0;
        rq.cmd           = cam_pkg::CMD_ADD;
        rq.camp_id       = id;
        rq.camp_price    = price;
        rq.country_code  = cc;
        rq.camp_width    = w;
        rq.camp_height   = h;
        // fields an add ignores carry noise
        rq.floor_price   = $urandom();
        rq.has_banner    = 1'($urandom_range(0, 1));
        rq.banner_width  = 16'($urandom());
        rq.banner_height = 16'($urandom());
        return rq;
    endfunction

    function automatic cam_pkg::req_t make_match(input logic [15:0] cc,
                                                 input logic [31:0] floor_p,
                                                 input logic hb, input logic [15:0] bw,
                                                 input logic [15:0] bh);
        cam_pkg::req_t rq;
        rq               = '0;
        rq.cmd           = cam_pkg::CMD_MATCH;
        rq.camp_id       = $urandom();
        rq.camp_price    = $urandom();
        rq.camp_width    = 16'($urandom());
        rq.camp_height   = 16'($urandom());
        rq.country_code  = cc;
        rq.floor_price   = floor_p;
        rq.has_banner    = hb;
        rq.banner_width  = bw;
        rq.banner_height = bh;
        return rq;
    endfunction

    function automatic logic [15:0] pool_country();
        case ($urandom_range(0, 3))
            0:       return CC_US;
            1:       return CC_DE;
            2:       return CC_FR;
            default: return CC_JP;
        endcase
    endfunction

    // {width, height} from the common ad sizes
    function automatic logic [31:0] pool_size();
        case ($urandom_range(0, 3))
            0:       return {16'd300, 16'd250};
            1:       return {16'd728, 16'd90};
            2:       return {16'd160, 16'd600};
            default: return {16'd320, 16'd50};
        endcase
    endfunction

    function automatic logic [31:0] pool_price();
        case ($urandom_range(0, 4))
            0:       return 32'd1000;
            1:       return 32'd2500;
            2:       return 32'd5000;
            3:       return 32'd7500;
            default: return 32'd10000;
        endcase
    endfunction

    // Mostly pooled countries, sizes and prices so matches collide, ties and floors bite.
    function automatic cam_pkg::req_t rand_request();
        cam_pkg::req_t rq;
        int            roll;
        logic [31:0]   sz;
        logic [31:0]   price;
        logic [31:0]   floor_p;
        logic [15:0]   cc;
        cc   = ($urandom_range(0, 99) < 85) ? pool_country() : 16'($urandom());
        sz   = ($urandom_range(0, 99) < 80) ? pool_size() : $urandom();
        roll = int'($urandom_range(0, 99));
        if ($urandom_range(0, 99) < 40) begin
            if (roll < 40)      price = pool_price();
            else if (roll < 50) price = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'd0;
            else if (roll < 80) price = $urandom_range(0, 20000);
            else                price = $urandom();
            rq = make_add($urandom(), price, cc, sz[31:16], sz[15:0]);
        end else begin
            if (roll < 35)                       floor_p = 32'd0;
            else if (roll < 60 && tbl_count > 0) floor_p = tbl_price[$urandom_range(0, tbl_count - 1)];
            else if (roll < 85)                  floor_p = $urandom_range(0, 20000);
            else                                 floor_p = $urandom();
            if ($urandom_range(0, 99) < 30) sz = $urandom();
            rq = make_match(cc, floor_p, 1'($urandom_range(0, 1)), sz[31:16], sz[15:0]);
        end
        return rq;
    endfunction

    // Driver: presents the next pending item, idling at random between items.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                predict_auction(presented);
                items_sent++;
            end
            if (request_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                presented = request_queue.pop_front();
                s_valid         <= 1'b1;
                s_cmd           <= presented.cmd;
                s_camp_id       <= presented.camp_id;
                s_camp_price    <= presented.camp_price;
                s_country_code  <= presented.country_code;
                s_camp_width    <= presented.camp_width;
                s_camp_height   <= presented.camp_height;
                s_floor_price   <= presented.floor_price;
                s_has_banner    <= presented.has_banner;
                s_banner_width  <= presented.banner_width;
                s_banner_height <= presented.banner_height;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each accepted result against the oldest predicted outcome.
    always @(posedge aclk) begin
        cam_pkg::res_t want;
        if (aresetn) begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            if (m_valid && m_ready) begin
                if (auction_outcomes.size() == 0) begin
                    $error("result with no item outstanding: status %0d", m_status);
                    fail_count++;
                end else begin
                    want = auction_outcomes.pop_front();
                    status_seen[m_status]++;
                    if (m_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_status);
                        fail_count++;
                    end
                    if (m_win_id !== want.win_id) begin
                        $error("win_id: expected %h, got %h", want.win_id, m_win_id);
                        fail_count++;
                    end
                    if (m_win_price !== want.win_price) begin
                        $error("win_price: expected %h, got %h", want.win_price, m_win_price);
                        fail_count++;
                    end
                    if (m_win_width !== want.win_width) begin
                        $error("win_width: expected %h, got %h", want.win_width, m_win_width);
                        fail_count++;
                    end
                    if (m_win_height !== want.win_height) begin
                        $error("win_height: expected %h, got %h", want.win_height, m_win_height);
                        fail_count++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $error("cycle limit hit, %0d items pending, %0d results outstanding",
                   request_queue.size(), auction_outcomes.size());
            $display("** campaign_auction_match_top: FAILED **");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty table, field extremes, floors at and above price, banners, ties
        queue_item(make_match(CC_US, 32'd0, 1'b0, 16'd0, 16'd0));
        queue_item(make_add(32'd0, 32'd0, 16'h0000, 16'h0000, 16'h0000));
        queue_item(make_add(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        queue_item(make_add(32'd1, 32'd5000, CC_US, 16'd300, 16'd250));
        queue_item(make_add(32'd2, 32'd5000, CC_US, 16'd728, 16'd90));
        queue_item(make_match(CC_US, 32'd0, 1'b0, 16'hFFFF, 16'hFFFF));
        queue_item(make_add(32'd3, 32'd7000, CC_US, 16'd300, 16'd250));
        queue_item(make_add(32'd4, 32'd7000, CC_US, 16'd728, 16'd90));
        queue_item(make_match(CC_US, 32'd0, 1'b0, 16'd0, 16'd0));
        queue_item(make_match(CC_US, 32'd7000, 1'b0, 16'd1, 16'd1));
        queue_item(make_match(CC_US, 32'd7001, 1'b0, 16'd0, 16'd0));
        queue_item(make_match(CC_US, 32'd0, 1'b1, 16'd728, 16'd90));
        queue_item(make_match(CC_US, 32'd5001, 1'b1, 16'd300, 16'd250));
        queue_item(make_match(CC_US, 32'd0, 1'b1, 16'd160, 16'd600));
        queue_item(make_match(16'h0000, 32'd0, 1'b1, 16'h0000, 16'h0000));
        queue_item(make_match(16'h0000, 32'd1, 1'b0, 16'd0, 16'd0));
        queue_item(make_match(16'hFFFF, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 16'hFFFF));
        queue_item(make_match(16'hFFFF, 32'hFFFF_FFFF, 1'b0, 16'h1234, 16'h5678));
        queue_item(make_match(CC_DE, 32'd0, 1'b0, 16'd0, 16'd0));

        for (int p = PACE_FREE; p <= PACE_BOTH; p++) begin
            case (pace_t'(p))
                PACE_FREE:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                PACE_SEND_IDLE:  begin send_idle_pct = 74; recv_stall_pct = 0;  end
                PACE_RECV_STALL: begin send_idle_pct = 0;  recv_stall_pct = 74; end
                default:         begin send_idle_pct = 8;  recv_stall_pct = 8;  end
            endcase
            // keep the queue short so random floors track the current table
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                while (request_queue.size() >= 2) @(negedge aclk);
                queue_item(rand_request());
            end
        end

        while (request_queue.size() > 0 || s_valid || auction_outcomes.size() > 0)
            @(negedge aclk);
        repeat (MAX_ENTRIES + 8) @(posedge aclk);

        $display("Sent %0d items through four pacing phases, table filled to %0d of %0d.",
                 items_sent, tbl_count, MAX_ENTRIES);
        $display("Results: %0d added, %0d table full, %0d matched, %0d unmatched.",
                 status_seen[cam_pkg::ST_ADDED], status_seen[cam_pkg::ST_FULL],
                 status_seen[cam_pkg::ST_FOUND], status_seen[cam_pkg::ST_NONE]);
        if (fail_count == 0 && auction_outcomes.size() == 0) begin
            $display("** campaign_auction_match_top: PASSED **");
        end else begin
            $display("** campaign_auction_match_top: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire
